>>> design/stb_pkg.sv
package stb_pkg;

  localparam int SPRITE_SIDE = 64;
  localparam int SCREEN_W    = 240;
  localparam int SCREEN_H    = 160;

  localparam int SS_LG     = $clog2(SPRITE_SIDE);
  localparam int TILE_AW   = 12;
  localparam int TILE_DEPTH = 1 << TILE_AW;
  localparam int PAL_AW    = 8;
  localparam int PAL_DEPTH = 1 << PAL_AW;
  localparam int FB_W      = 16;
  localparam int SIZE_MAX  = 64;

  localparam logic [1:0] OP_TILE = 2'd0;
  localparam logic [1:0] OP_PAL  = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 9;

  localparam logic [CFG_IW-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IW-1:0] REG_READY  = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] mem_addr;
    logic [15:0] mem_data;
    logic [5:0]  dest_col;
    logic [5:0]  dest_row;
  } in_word_t;

  typedef struct packed {
    logic            write_enable;
    logic [FB_W-1:0] fb_address;
    logic [15:0]     color;
  } out_word_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [TILE_AW-1:0] addr;
    logic [7:0]         wdata;
  } tile_req_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [15:0]       wdata;
  } pal_req_t;

  typedef struct packed {
    tile_req_t tile;
    pal_req_t  pal;
  } store_req_t;

endpackage

>>> design/stb_stores.sv
module stb_stores (
  input  logic              clk,
  input  stb_pkg::store_req_t req,
  output logic [7:0]        tile_q,
  output logic [15:0]       pal_q
);
  import stb_pkg::*;

  logic [7:0]  tile_mem [TILE_DEPTH];
  logic [15:0] pal_mem  [PAL_DEPTH];
  logic [7:0]  tile_q_r;
  logic [15:0] pal_q_r;

  always_ff @(posedge clk) begin
    if (req.tile.en) begin
      if (req.tile.we) begin
        tile_mem[req.tile.addr] <= req.tile.wdata;
      end
      tile_q_r <= tile_mem[req.tile.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pal.en) begin
      if (req.pal.we) begin
        pal_mem[req.pal.addr] <= req.pal.wdata;
      end
      pal_q_r <= pal_mem[req.pal.addr];
    end
  end

  assign tile_q = tile_q_r;
  assign pal_q  = pal_q_r;

endmodule

>>> design/scaled_tiled_sprite_blit_unit.sv
// scaled sprite blit: one destination pixel per word
// in channel (in_valid/in_ready/in_data): op 0 loads a tile byte, op 1 a
// palette color, op 2 draws the pixel at dest_col/dest_row of the scaled
// sprite; op 3 does nothing. every input word gives exactly one out word,
// in order. out_data carries write_enable, fb_address and color; all
// three are zero when nothing is to be written.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): placement, size
// and sprite_ready registers; always ready, write only while idle.
// throughput: one word per cycle while out_ready is high. each word passes
// through a 9 register pipeline: entry and clip check, one quotient bit
// per stage for the source column and row (6 stages), tile memory read,
// palette memory read. when out_ready is low the pipeline keeps taking
// words until its empty stages fill up; nothing is dropped or repeated.
// reset empties the pipeline and sets placement 0,0, size 64x64 and
// sprite_ready 0. the tile and palette memories are not cleared and must
// be loaded before they are drawn from.
module scaled_tiled_sprite_blit_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  stb_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stb_pkg::out_word_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [stb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [stb_pkg::CFG_DW-1:0] cfg_data
);
  import stb_pkg::*;

  localparam int TS = SS_LG + 1;
  localparam int PS = SS_LG + 2;
  localparam int NS = SS_LG + 3;

  typedef struct packed {
    logic [1:0]       op;
    logic [11:0]      addr;
    logic [15:0]      data;
    logic             vis;
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic [6:0]       rx;
    logic [6:0]       ry;
    logic [SS_LG-1:0] qx;
    logic [SS_LG-1:0] qy;
    logic [FB_W-1:0]  fb;
  } pipe_t;

  logic signed [8:0] dest_left_r;
  logic signed [8:0] dest_top_r;
  logic [6:0]        dest_width_r;
  logic [6:0]        dest_height_r;
  logic              sprite_ready_r;

  logic [6:0] w_sat;
  logic [6:0] h_sat;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  pipe_t         st_r   [NS];
  pipe_t         st_nxt [NS];

  store_req_t  req;
  logic [7:0]  tile_q;
  logic [15:0] pal_q;

  function automatic pipe_t div_step(pipe_t s, logic [6:0] w, logic [6:0] h);
    pipe_t      o;
    logic [7:0] tx;
    logic [7:0] ty;
    o  = s;
    tx = {s.rx, 1'b0};
    ty = {s.ry, 1'b0};
    if (tx >= {1'b0, w}) begin
      o.rx = 7'(tx - {1'b0, w});
      o.qx = {s.qx[SS_LG-2:0], 1'b1};
    end else begin
      o.rx = 7'(tx);
      o.qx = {s.qx[SS_LG-2:0], 1'b0};
    end
    if (ty >= {1'b0, h}) begin
      o.ry = 7'(ty - {1'b0, h});
      o.qy = {s.qy[SS_LG-2:0], 1'b1};
    end else begin
      o.ry = 7'(ty);
      o.qy = {s.qy[SS_LG-2:0], 1'b0};
    end
    return o;
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_left_r    <= '0;
      dest_top_r     <= '0;
      dest_width_r   <= 7'(SIZE_MAX);
      dest_height_r  <= 7'(SIZE_MAX);
      sprite_ready_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT:   dest_left_r    <= $signed(cfg_data);
        REG_TOP:    dest_top_r     <= $signed(cfg_data);
        REG_WIDTH:  dest_width_r   <= cfg_data[6:0];
        REG_HEIGHT: dest_height_r  <= cfg_data[6:0];
        REG_READY:  sprite_ready_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (dest_width_r == '0) begin
      w_sat = 7'd1;
    end else if (dest_width_r > 7'(SIZE_MAX)) begin
      w_sat = 7'(SIZE_MAX);
    end else begin
      w_sat = dest_width_r;
    end
    if (dest_height_r == '0) begin
      h_sat = 7'd1;
    end else if (dest_height_r > 7'(SIZE_MAX)) begin
      h_sat = 7'(SIZE_MAX);
    end else begin
      h_sat = dest_height_r;
    end
  end

  // stage enables, a stage loads when it is empty or drains
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // stage logic
  always_comb begin
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic              on_x;
    logic              on_y;
    logic              in_rect;
    px = $signed({dest_left_r[8], dest_left_r}) + $signed({4'b0, in_data.dest_col});
    py = $signed({dest_top_r[8], dest_top_r}) + $signed({4'b0, in_data.dest_row});
    on_x    = (int'(px) >= 0) && (int'(px) < SCREEN_W);
    on_y    = (int'(py) >= 0) && (int'(py) < SCREEN_H);
    in_rect = ({1'b0, in_data.dest_col} < w_sat) && ({1'b0, in_data.dest_row} < h_sat);

    st_nxt[0].op   = in_data.op;
    st_nxt[0].addr = in_data.mem_addr;
    st_nxt[0].data = in_data.mem_data;
    st_nxt[0].vis  = (in_data.op == OP_DRAW) && sprite_ready_r && in_rect && on_x && on_y;
    st_nxt[0].px   = px;
    st_nxt[0].py   = py;
    st_nxt[0].rx   = {1'b0, in_data.dest_col};
    st_nxt[0].ry   = {1'b0, in_data.dest_row};
    st_nxt[0].qx   = '0;
    st_nxt[0].qy   = '0;
    st_nxt[0].fb   = '0;

    for (int k = 1; k <= SS_LG; k++) begin
      st_nxt[k] = div_step(st_r[k-1], w_sat, h_sat);
    end

    st_nxt[TS]    = st_r[TS-1];
    st_nxt[TS].fb = FB_W'(int'(st_r[TS-1].py) * SCREEN_W + int'(st_r[TS-1].px));

    st_nxt[PS]     = st_r[PS-1];
    st_nxt[PS].vis = st_r[PS-1].vis && (tile_q != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // sprite stores, accessed as a word moves into the tile and palette stages
  always_comb begin
    logic [SS_LG-1:0] qx;
    logic [SS_LG-1:0] qy;
    qx = st_r[TS-1].qx;
    qy = st_r[TS-1].qy;

    req.tile.en    = en[TS];
    req.tile.we    = v_r[TS-1] && (st_r[TS-1].op == OP_TILE);
    req.tile.wdata = st_r[TS-1].data[7:0];
    if (req.tile.we) begin
      req.tile.addr = st_r[TS-1].addr;
    end else begin
      req.tile.addr = TILE_AW'((int'(qy >> 3) << (SS_LG + 3)) | (int'(qx >> 3) << 6)
                               | (int'(qy[2:0]) << 3) | int'(qx[2:0]));
    end

    req.pal.en    = en[PS];
    req.pal.we    = v_r[PS-1] && (st_r[PS-1].op == OP_PAL);
    req.pal.wdata = st_r[PS-1].data;
    if (req.pal.we) begin
      req.pal.addr = st_r[PS-1].addr[PAL_AW-1:0];
    end else begin
      req.pal.addr = tile_q;
    end
  end

  stb_stores u_stores (
    .clk    (clk),
    .req    (req),
    .tile_q (tile_q),
    .pal_q  (pal_q)
  );

  // result
  assign out_valid              = v_r[NS-1];
  assign out_data.write_enable  = st_r[PS].vis;
  assign out_data.fb_address    = st_r[PS].vis ? st_r[PS].fb : '0;
  assign out_data.color         = st_r[PS].vis ? pal_q : '0;

endmodule
